FILE: hw/rtl/i8mm_pkg.sv
// Shared types and constants for the int8 matrix multiply block.
// Used by i8mm_cell and int8_matmul_offset_accumulate_top; depends on nothing.
package i8mm_pkg;

	// Configuration port.
	localparam int ADDR_W = 5;
	localparam int DATA_W = 32;

	// Register indexes on the configuration port (byte address is 4 times the index).
	typedef enum logic [2:0] {
		REG_ROWS_M   = 3'd0,
		REG_INNER_N  = 3'd1,
		REG_COLS_P   = 3'd2,
		REG_A_OFFSET = 3'd3,
		REG_B_OFFSET = 3'd4,
		REG_C_OFFSET = 3'd5
	} reg_idx_t;

	// Register field widths.
	localparam int ROWS_W = 11;
	localparam int INNER_W = 7;
	localparam int COLS_W = 5;
	localparam int OFF_W = 9;

	// Commands of the input word.
	localparam logic CMD_LOAD_B = 1'b0;
	localparam logic CMD_A_ELEM = 1'b1;

	// Operand and product widths: an int8 plus a 9-bit offset fits in 10 bits.
	localparam int OPND_W = 10;
	localparam int PROD_W = 2 * OPND_W;

	// Control that the top level broadcasts to every cell of the chain.
	typedef struct packed {
		logic                     mac_s1;
		logic signed [OPND_W-1:0] av_s1;
		logic                     mac_s2;
		logic                     first_s2;
		logic                     last_s2;
		logic signed [OFF_W-1:0]  b_offset;
		logic [31:0]              c_offset;
		logic                     shift;
	} cell_ctl_t;

endpackage

FILE: hw/rtl/i8mm_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; instantiated once per column cell for its slice of matrix B.
module i8mm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

FILE: hw/rtl/i8mm_cell.sv
// One column cell: its column of B, a multiplier, an accumulator and one result slot
// that shifts toward cell 0. Depends on i8mm_pkg and i8mm_ram.
module i8mm_cell #(
	parameter int DEPTH = 64,
	parameter int AW = 6
) (
	input  logic                  clk,
	input  i8mm_pkg::cell_ctl_t   ctl,
	input  logic                  b_we,
	input  logic [AW-1:0]         b_waddr,
	input  logic [7:0]            b_wdata,
	input  logic [AW-1:0]         b_raddr,
	input  logic [31:0]           sum_in,
	output logic [31:0]           sum_out
);

	logic [7:0]                                b_rdata;
	logic signed [i8mm_pkg::OPND_W-1:0]        bv;
	logic signed [i8mm_pkg::PROD_W-1:0]        prod;
	logic signed [i8mm_pkg::PROD_W-1:0]        prod_s2;
	logic [31:0]                               acc_q;
	logic [31:0]                               acc_next;
	logic [31:0]                               slot_q;

	i8mm_ram #(
		.WIDTH(8),
		.DEPTH(DEPTH)
	) u_bram (
		.clk  (clk),
		.we   (b_we),
		.waddr(b_waddr),
		.wdata(b_wdata),
		.raddr(b_raddr),
		.rdata(b_rdata)
	);

	assign bv = $signed({{2{b_rdata[7]}}, b_rdata}) + $signed({ctl.b_offset[8], ctl.b_offset});
	assign prod = ctl.av_s1 * bv;

	// A row restarts its sum from the constant offset.
	assign acc_next = (ctl.first_s2 ? ctl.c_offset : acc_q)
		+ {{(32 - i8mm_pkg::PROD_W){prod_s2[i8mm_pkg::PROD_W-1]}}, prod_s2};

	always_ff @(posedge clk) begin
		if (ctl.mac_s1) begin
			prod_s2 <= prod;
		end
		if (ctl.mac_s2) begin
			acc_q <= acc_next;
		end
		if (ctl.mac_s2 && ctl.last_s2) begin
			slot_q <= acc_next;
		end else if (ctl.shift) begin
			slot_q <= sum_in;
		end
	end

	assign sum_out = slot_q;

endmodule

FILE: hw/rtl/int8_matmul_offset_accumulate_top.sv
// Top level of the int8 matrix multiply with offsets: register file, sequencing
// and a chain of column cells. Depends on i8mm_pkg, i8mm_cell and i8mm_ram.
//
// Use: program rows_m, inner_n, cols_p and the three offsets through the APB
// port while the block is idle. Then send words on the item channel
// (item_valid/item_ready): command 0 loads the next element of B in row-major
// order, command 1 streams the next element of A in row-major order. Each A
// element is multiplied into one accumulator per column, one cell per column,
// all cells working in the same cycle.
// When an A element closes a row, the column sums are copied into the cells'
// result slots, which form a shift chain; the chain drains one word per cycle
// on the result channel (result_valid/result_ready), column 0 first, tagged
// with row and column, and with row_last and matrix_last flags.
// The first result of a row appears once the element that closes the row has
// passed stage 1 and stage 2 and filled the result slots. Throughput: one item
// per cycle, set by the three-stage cell pipeline (B read, multiply,
// accumulate). An element that closes a row is held off while the previous
// row's results are still in the pipeline or in the chain. When the receiver
// stalls, the chain holds its words and items keep flowing until the next row
// end. Reset clears all control state, sets the dimensions to 1 and the
// offsets to 0; the B store holds no value until it is loaded.
module int8_matmul_offset_accumulate_top #(
	parameter int MAX_INNER = 64,
	parameter int MAX_COLS = 16,
	parameter int MAX_ROWS = 1024
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// Configuration port
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [i8mm_pkg::ADDR_W-1:0]   paddr,
	input  logic [i8mm_pkg::DATA_W-1:0]   pwdata,
	output logic [i8mm_pkg::DATA_W-1:0]   prdata,
	output logic                          pready,
	// Item channel
	input  logic                          item_valid,
	output logic                          item_ready,
	input  logic                          command,
	input  logic signed [7:0]             element_value,
	// Result channel
	output logic                          result_valid,
	input  logic                          result_ready,
	output logic signed [31:0]            result_value,
	output logic [9:0]                    result_row,
	output logic [3:0]                    result_column,
	output logic                          row_last,
	output logic                          matrix_last
);

	// Limits reachable through the register widths.
	localparam int N_LIM = (MAX_INNER < 127) ? MAX_INNER : 127;
	localparam int P_LIM = (MAX_COLS < 31) ? MAX_COLS : 31;
	localparam int R_LIM = (MAX_ROWS < 2047) ? MAX_ROWS : 2047;
	localparam int NCW = $clog2(N_LIM + 1);
	localparam int PCW = $clog2(P_LIM + 1);
	localparam int RCW = $clog2(R_LIM + 1);
	localparam int AW = (N_LIM > 1) ? $clog2(N_LIM) : 1;

	// Configuration registers.
	logic [i8mm_pkg::ROWS_W-1:0]         rows_m_q;
	logic [i8mm_pkg::INNER_W-1:0]        inner_n_q;
	logic [i8mm_pkg::COLS_W-1:0]         cols_p_q;
	logic signed [i8mm_pkg::OFF_W-1:0]   a_offset_q;
	logic signed [i8mm_pkg::OFF_W-1:0]   b_offset_q;
	logic [31:0]                         c_offset_q;

	logic                 cfg_wr;
	i8mm_pkg::reg_idx_t   cfg_idx;
	logic                 dim_wr;

	// Effective dimensions after clamping.
	logic [RCW-1:0] m_eff;
	logic [NCW-1:0] n_eff;
	logic [PCW-1:0] p_eff;

	// Positions.
	logic [NCW-1:0] load_row_q;
	logic [PCW-1:0] load_col_q;
	logic [NCW-1:0] a_col_q;
	logic [RCW-1:0] a_row_q;

	// Pipeline control.
	logic                              accept;
	logic                              is_a;
	logic                              is_b;
	logic                              row_end;
	logic                              mac_s1;
	logic                              first_s1;
	logic                              last_s1;
	logic signed [i8mm_pkg::OPND_W-1:0] av_s1;
	logic                              mac_s2;
	logic                              first_s2;
	logic                              last_s2;

	// Result drain.
	logic [PCW-1:0] out_cnt_q;
	logic [PCW-1:0] out_col_q;
	logic [RCW-1:0] emit_row_q;
	logic           emit_mlast_q;
	logic           out_take;

	i8mm_pkg::cell_ctl_t ctl;
	logic [31:0]         cell_sum [P_LIM];

	// ---------------- Configuration port ----------------
	assign pready = 1'b1;
	assign cfg_idx = i8mm_pkg::reg_idx_t'(paddr[4:2]);
	assign cfg_wr = psel && penable && pwrite;
	assign dim_wr = cfg_wr && (cfg_idx == i8mm_pkg::REG_ROWS_M
		|| cfg_idx == i8mm_pkg::REG_INNER_N || cfg_idx == i8mm_pkg::REG_COLS_P);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_m_q   <= i8mm_pkg::ROWS_W'(1);
			inner_n_q  <= i8mm_pkg::INNER_W'(1);
			cols_p_q   <= i8mm_pkg::COLS_W'(1);
			a_offset_q <= '0;
			b_offset_q <= '0;
			c_offset_q <= '0;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				i8mm_pkg::REG_ROWS_M: begin
					rows_m_q <= pwdata[i8mm_pkg::ROWS_W-1:0];
				end
				i8mm_pkg::REG_INNER_N: begin
					inner_n_q <= pwdata[i8mm_pkg::INNER_W-1:0];
				end
				i8mm_pkg::REG_COLS_P: begin
					cols_p_q <= pwdata[i8mm_pkg::COLS_W-1:0];
				end
				i8mm_pkg::REG_A_OFFSET: begin
					a_offset_q <= pwdata[i8mm_pkg::OFF_W-1:0];
				end
				i8mm_pkg::REG_B_OFFSET: begin
					b_offset_q <= pwdata[i8mm_pkg::OFF_W-1:0];
				end
				i8mm_pkg::REG_C_OFFSET: begin
					c_offset_q <= pwdata;
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (cfg_idx)
			i8mm_pkg::REG_ROWS_M:   prdata = 32'(rows_m_q);
			i8mm_pkg::REG_INNER_N:  prdata = 32'(inner_n_q);
			i8mm_pkg::REG_COLS_P:   prdata = 32'(cols_p_q);
			i8mm_pkg::REG_A_OFFSET: prdata = 32'(unsigned'(a_offset_q));
			i8mm_pkg::REG_B_OFFSET: prdata = 32'(unsigned'(b_offset_q));
			i8mm_pkg::REG_C_OFFSET: prdata = c_offset_q;
			default:                prdata = '0;
		endcase
	end

	// A zero dimension counts as one, and a dimension above its limit as the limit.
	always_comb begin
		if (rows_m_q == '0) begin
			m_eff = RCW'(1);
		end else if (32'(rows_m_q) > R_LIM) begin
			m_eff = RCW'(R_LIM);
		end else begin
			m_eff = RCW'(rows_m_q);
		end
		if (inner_n_q == '0) begin
			n_eff = NCW'(1);
		end else if (32'(inner_n_q) > N_LIM) begin
			n_eff = NCW'(N_LIM);
		end else begin
			n_eff = NCW'(inner_n_q);
		end
		if (cols_p_q == '0) begin
			p_eff = PCW'(1);
		end else if (32'(cols_p_q) > P_LIM) begin
			p_eff = PCW'(P_LIM);
		end else begin
			p_eff = PCW'(cols_p_q);
		end
	end

	// ---------------- Item acceptance ----------------
	// Only one row end may be in flight: the element that closes a row waits until
	// the previous row has left the pipeline and the result chain.
	assign item_ready = !((a_col_q == n_eff - NCW'(1)) && (last_s1 || last_s2 || result_valid));
	assign accept = item_valid && item_ready;
	assign is_a = accept && (command == i8mm_pkg::CMD_A_ELEM);
	assign is_b = accept && (command == i8mm_pkg::CMD_LOAD_B);
	assign row_end = a_col_q == n_eff - NCW'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_row_q   <= '0;
			load_col_q   <= '0;
			a_col_q      <= '0;
			a_row_q      <= '0;
			emit_row_q   <= '0;
			emit_mlast_q <= 1'b0;
		end else if (dim_wr) begin
			load_row_q <= '0;
			load_col_q <= '0;
			a_col_q    <= '0;
			a_row_q    <= '0;
		end else if (is_b) begin
			// A B load also restarts the A stream.
			a_col_q <= '0;
			a_row_q <= '0;
			if (load_col_q == p_eff - PCW'(1)) begin
				load_col_q <= '0;
				load_row_q <= (load_row_q == n_eff - NCW'(1)) ? '0 : load_row_q + NCW'(1);
			end else begin
				load_col_q <= load_col_q + PCW'(1);
			end
		end else if (is_a) begin
			if (row_end) begin
				a_col_q      <= '0;
				emit_row_q   <= a_row_q;
				emit_mlast_q <= a_row_q == m_eff - RCW'(1);
				a_row_q      <= (a_row_q == m_eff - RCW'(1)) ? '0 : a_row_q + RCW'(1);
			end else begin
				a_col_q <= a_col_q + NCW'(1);
			end
		end
	end

	// Stage 1 holds the offset A element while the cells read their B entry;
	// stage 2 holds the products.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mac_s1   <= 1'b0;
			first_s1 <= 1'b0;
			last_s1  <= 1'b0;
			mac_s2   <= 1'b0;
			first_s2 <= 1'b0;
			last_s2  <= 1'b0;
		end else begin
			mac_s1   <= is_a;
			first_s1 <= is_a && (a_col_q == '0);
			last_s1  <= is_a && row_end;
			mac_s2   <= mac_s1;
			first_s2 <= first_s1;
			last_s2  <= last_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (is_a) begin
			av_s1 <= $signed({{2{element_value[7]}}, element_value})
				+ $signed({a_offset_q[8], a_offset_q});
		end
	end

	// ---------------- Result drain ----------------
	assign result_valid = out_cnt_q != '0;
	assign out_take = result_valid && result_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_cnt_q <= '0;
			out_col_q <= '0;
		end else if (mac_s2 && last_s2) begin
			out_cnt_q <= p_eff;
			out_col_q <= '0;
		end else if (out_take) begin
			out_cnt_q <= out_cnt_q - PCW'(1);
			out_col_q <= out_col_q + PCW'(1);
		end
	end

	assign result_value  = cell_sum[0];
	assign result_row    = 10'(emit_row_q);
	assign result_column = 4'(out_col_q);
	assign row_last      = out_col_q == p_eff - PCW'(1);
	assign matrix_last   = row_last && emit_mlast_q;

	// ---------------- Column cells ----------------
	always_comb begin
		ctl.mac_s1   = mac_s1;
		ctl.av_s1    = av_s1;
		ctl.mac_s2   = mac_s2;
		ctl.first_s2 = first_s2;
		ctl.last_s2  = last_s2;
		ctl.b_offset = b_offset_q;
		ctl.c_offset = c_offset_q;
		ctl.shift    = out_take;
	end

	for (genvar k = 0; k < P_LIM; k++) begin : g_cell
		logic [31:0] nxt;

		if (k == P_LIM - 1) begin : g_end
			assign nxt = '0;
		end else begin : g_mid
			assign nxt = cell_sum[k+1];
		end

		i8mm_cell #(
			.DEPTH(N_LIM),
			.AW   (AW)
		) u_cell (
			.clk    (clk),
			.ctl    (ctl),
			.b_we   (is_b && (load_col_q == PCW'(k))),
			.b_waddr(load_row_q[AW-1:0]),
			.b_wdata(element_value),
			.b_raddr(a_col_q[AW-1:0]),
			.sum_in (nxt),
			.sum_out(cell_sum[k])
		);
	end

endmodule

FILE: bench/tb_int8_matmul_offset_accumulate_top.sv
// Self-checking testbench for int8_matmul_offset_accumulate_top.
// Depends on i8mm_pkg and the RTL of the block; holds its own model of the multiply.
// Directed cases first, then random matrices under random idling and back-pressure.
module tb_int8_matmul_offset_accumulate_top;
	timeunit 1ns;
	timeprecision 1ps;

	import i8mm_pkg::*;

	localparam int MAX_INNER = 64;
	localparam int MAX_COLS = 16;
	localparam int MAX_ROWS = 1024;
	localparam int RANDOM_ITEMS = 360;
	// Cycles that the receiver holds off during the back-pressure test.
	localparam int LONG_HOLD = 400;
	// Quiet cycles after the last result before the configuration may change.
	localparam int SETTLE_CYCLES = 10;
	// The longest quiet stretch in a correct run is the long hold-off above.
	localparam int STALL_LIMIT = 3000;
	localparam int MAX_REPORTS = 100;

	// One result word as the block should deliver it.
	typedef struct {
		logic signed [31:0] value;
		logic [9:0]         row;
		logic [3:0]         column;
		logic               row_last;
		logic               matrix_last;
	} mm_result_t;

	logic                   clk;
	logic                   arst_n = 1'b0;
	logic                   psel = 1'b0;
	logic                   penable = 1'b0;
	logic                   pwrite = 1'b0;
	logic [ADDR_W-1:0]      paddr = '0;
	logic [DATA_W-1:0]      pwdata = '0;
	logic [DATA_W-1:0]      prdata;
	logic                   pready;
	logic                   item_valid = 1'b0;
	logic                   item_ready;
	logic                   command = CMD_LOAD_B;
	logic signed [7:0]      element_value = '0;
	logic                   result_valid;
	logic                   result_ready = 1'b0;
	logic signed [31:0]     result_value;
	logic [9:0]             result_row;
	logic [3:0]             result_column;
	logic                   row_last;
	logic                   matrix_last;

	// Mirror of the configuration registers, at their reset values.
	logic [10:0]            cfg_rows = 11'd1;
	logic [6:0]             cfg_inner = 7'd1;
	logic [4:0]             cfg_cols = 5'd1;
	logic signed [8:0]      cfg_a_off = '0;
	logic signed [8:0]      cfg_b_off = '0;
	logic [31:0]            cfg_c_off = '0;

	// Mirror of the block's state: the B store, the column sums and the
	// three stream positions.
	logic signed [7:0]      b_image [MAX_INNER*MAX_COLS];
	logic [31:0]            col_acc [MAX_COLS];
	int unsigned            load_slot = 0;
	int unsigned            a_col_idx = 0;
	int unsigned            a_row_idx = 0;

	// Result words predicted but not yet delivered, oldest first.
	mm_result_t             pending_results [$];

	int                     mismatch_count = 0;
	int                     stalled_cycles = 0;
	bit                     send_quiet = 1'b0;
	bit                     recv_quiet = 1'b0;
	// Set by the back-pressure test: the sender offers words back to back and
	// the receiver starts one long hold-off.
	bit                     rush_items = 1'b0;
	bit                     hold_request = 1'b0;

	int8_matmul_offset_accumulate_top #(
		.MAX_INNER(MAX_INNER),
		.MAX_COLS(MAX_COLS),
		.MAX_ROWS(MAX_ROWS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.command(command),
		.element_value(element_value),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result_value(result_value),
		.result_row(result_row),
		.result_column(result_column),
		.row_last(row_last),
		.matrix_last(matrix_last)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// A dimension register of zero acts as 1, one above its maximum as the maximum.
	function automatic int unsigned eff_dim(input int unsigned raw, input int unsigned limit);
		if (raw == 0)
			return 1;
		return (raw > limit) ? limit : raw;
	endfunction

	// Pause before the next word on either side. Each side now and then flips
	// into a quiet stretch where it never idles.
	function automatic int draw_pause(inout bit quiet);
		if ($urandom_range(0, 23) == 0)
			quiet = !quiet;
		return quiet ? 0 : int'($urandom_range(0, 17));
	endfunction

	function automatic logic signed [7:0] pick_element();
		case ($urandom_range(0, 7))
			0: return -8'sd128;
			1: return 8'sd127;
			default: return 8'($urandom);
		endcase
	endfunction

	function automatic logic signed [8:0] pick_offset();
		case ($urandom_range(0, 5))
			0: return -9'sd256;
			1: return 9'sd255;
			default: return 9'($urandom);
		endcase
	endfunction

	function automatic logic [31:0] pick_c_offset();
		case ($urandom_range(0, 5))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	// Register writes as the block sees them. A dimension write sends the B
	// load and both A positions back to the start; an offset write does not.
	function automatic void note_reg_write(input reg_idx_t idx, input logic [31:0] value);
		case (idx)
			REG_ROWS_M:   cfg_rows = value[10:0];
			REG_INNER_N:  cfg_inner = value[6:0];
			REG_COLS_P:   cfg_cols = value[4:0];
			REG_A_OFFSET: cfg_a_off = value[8:0];
			REG_B_OFFSET: cfg_b_off = value[8:0];
			REG_C_OFFSET: cfg_c_off = value;
			default: ;
		endcase
		if (idx == REG_ROWS_M || idx == REG_INNER_N || idx == REG_COLS_P) begin
			load_slot = 0;
			a_col_idx = 0;
			a_row_idx = 0;
		end
	endfunction

	// Works out what one accepted word does to the multiply and queues the row
	// of results that it completes, if any.
	function automatic void predict_matmul_word(input logic cmd, input logic signed [7:0] elem);
		int unsigned m, n, p, k, base;
		logic signed [31:0] a_term, b_term;
		mm_result_t r;
		m = eff_dim(cfg_rows, MAX_ROWS);
		n = eff_dim(cfg_inner, MAX_INNER);
		p = eff_dim(cfg_cols, MAX_COLS);
		if (load_slot >= n * p)
			load_slot = 0;
		if (a_col_idx >= n)
			a_col_idx = 0;
		if (a_row_idx >= m)
			a_row_idx = 0;
		if (cmd == CMD_LOAD_B) begin
			// A B element also throws away the partial row of A.
			b_image[load_slot] = elem;
			load_slot++;
			if (load_slot >= n * p)
				load_slot = 0;
			a_col_idx = 0;
			a_row_idx = 0;
			return;
		end
		if (a_col_idx == 0)
			for (k = 0; k < p; k++)
				col_acc[k] = cfg_c_off;
		a_term = elem + cfg_a_off;
		base = a_col_idx * p;
		for (k = 0; k < p; k++) begin
			b_term = b_image[base + k] + cfg_b_off;
			col_acc[k] = col_acc[k] + a_term * b_term;
		end
		a_col_idx++;
		if (a_col_idx < n)
			return;
		a_col_idx = 0;
		for (k = 0; k < p; k++) begin
			r.value = col_acc[k];
			r.row = 10'(a_row_idx);
			r.column = 4'(k);
			r.row_last = (k == p - 1);
			r.matrix_last = (k == p - 1) && (a_row_idx + 1 == m);
			pending_results.push_back(r);
		end
		a_row_idx++;
		if (a_row_idx >= m)
			a_row_idx = 0;
	endfunction

	// One register write: setup cycle, then access cycle until pready, then a
	// return to idle so that back-to-back writes never touch psel twice in a step.
	task automatic write_reg(input reg_idx_t idx, input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		note_reg_write(idx, value);
		@(posedge clk);
	endtask

	// Offers one word on the item channel and returns at the edge that takes it.
	// Valid is left high so that a following word with no pause keeps it up.
	task automatic offer_word(input logic cmd, input logic signed [7:0] elem);
		int gap;
		gap = rush_items ? 0 : draw_pause(send_quiet);
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid <= 1'b1;
		command <= cmd;
		element_value <= elem;
		do @(posedge clk); while (!item_ready);
		predict_matmul_word(cmd, elem);
	endtask

	task automatic load_b_random(input int unsigned count);
		repeat (count) offer_word(CMD_LOAD_B, pick_element());
	endtask

	// Waits until every predicted word has come out and the pipeline is empty,
	// so that the configuration may be changed.
	task automatic settle_block();
		item_valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Reset state: 1 by 1 by 1 with zero offsets.
	task automatic test_reset_state();
		offer_word(CMD_LOAD_B, 8'sd100);
		offer_word(CMD_A_ELEM, -8'sd128);
		offer_word(CMD_A_ELEM, 8'sd127);
		settle_block();
	endtask

	// Extreme elements against extreme offsets, with c_offset at both ends so
	// that the sums wrap around 32 bits.
	task automatic test_operand_extremes();
		write_reg(REG_ROWS_M, 32'd1);
		write_reg(REG_INNER_N, 32'd2);
		write_reg(REG_COLS_P, 32'd2);
		write_reg(REG_A_OFFSET, 32'(9'sd255));
		write_reg(REG_B_OFFSET, 32'(-9'sd256));
		write_reg(REG_C_OFFSET, 32'h7FFF_FFFF);
		offer_word(CMD_LOAD_B, -8'sd128);
		offer_word(CMD_LOAD_B, 8'sd127);
		offer_word(CMD_LOAD_B, 8'sd127);
		offer_word(CMD_LOAD_B, -8'sd128);
		offer_word(CMD_A_ELEM, -8'sd128);
		offer_word(CMD_A_ELEM, 8'sd127);
		offer_word(CMD_A_ELEM, 8'sd127);
		offer_word(CMD_A_ELEM, -8'sd128);
		settle_block();
		write_reg(REG_A_OFFSET, 32'(-9'sd256));
		write_reg(REG_B_OFFSET, 32'(9'sd255));
		write_reg(REG_C_OFFSET, 32'h8000_0000);
		offer_word(CMD_A_ELEM, -8'sd128);
		offer_word(CMD_A_ELEM, 8'sd127);
		offer_word(CMD_A_ELEM, 8'sd0);
		offer_word(CMD_A_ELEM, -8'sd1);
		settle_block();
	endtask

	// Zero dimensions, and the ways the A stream restarts: a B element in the
	// middle of a row, a dimension write in the middle of a row, and an offset
	// write that must leave a half-done row alone.
	task automatic test_stream_restarts();
		write_reg(REG_ROWS_M, 32'd0);
		write_reg(REG_INNER_N, 32'd0);
		write_reg(REG_COLS_P, 32'd0);
		offer_word(CMD_LOAD_B, 8'sd3);
		offer_word(CMD_A_ELEM, 8'sd5);
		offer_word(CMD_A_ELEM, -8'sd7);
		settle_block();
		write_reg(REG_ROWS_M, 32'd3);
		write_reg(REG_INNER_N, 32'd2);
		write_reg(REG_COLS_P, 32'd2);
		load_b_random(4);
		offer_word(CMD_A_ELEM, pick_element());
		offer_word(CMD_LOAD_B, pick_element());
		offer_word(CMD_A_ELEM, pick_element());
		offer_word(CMD_A_ELEM, pick_element());
		offer_word(CMD_A_ELEM, pick_element());
		settle_block();
		write_reg(REG_COLS_P, 32'd2);
		offer_word(CMD_A_ELEM, pick_element());
		offer_word(CMD_A_ELEM, pick_element());
		offer_word(CMD_A_ELEM, pick_element());
		settle_block();
		write_reg(REG_C_OFFSET, pick_c_offset());
		offer_word(CMD_A_ELEM, pick_element());
		settle_block();
	endtask

	// Dimension registers at and beyond their maxima, the first shape with zero columns.
	task automatic test_wide_dims();
		write_reg(REG_ROWS_M, 32'(MAX_ROWS));
		write_reg(REG_INNER_N, 32'd127);
		write_reg(REG_COLS_P, 32'd0);
		write_reg(REG_A_OFFSET, 32'(pick_offset()));
		write_reg(REG_B_OFFSET, 32'(pick_offset()));
		write_reg(REG_C_OFFSET, pick_c_offset());
		load_b_random(MAX_INNER);
		repeat (2 * MAX_INNER) offer_word(CMD_A_ELEM, pick_element());
		settle_block();
		write_reg(REG_INNER_N, 32'd1);
		write_reg(REG_COLS_P, 32'd31);
		load_b_random(MAX_COLS);
		repeat (3) offer_word(CMD_A_ELEM, pick_element());
		settle_block();
		write_reg(REG_INNER_N, 32'd2);
		write_reg(REG_COLS_P, 32'(MAX_COLS));
		load_b_random(2 * MAX_COLS);
		repeat (4) offer_word(CMD_A_ELEM, pick_element());
		settle_block();
	endtask

	// The receiver holds off for a long stretch while every A word closes a
	// row of sixteen results, so the chain fills and the block stops taking words.
	task automatic test_backpressure();
		write_reg(REG_ROWS_M, 32'd8);
		write_reg(REG_INNER_N, 32'd1);
		write_reg(REG_COLS_P, 32'(MAX_COLS));
		load_b_random(MAX_COLS);
		hold_request = 1'b1;
		rush_items = 1'b1;
		repeat (24) offer_word(CMD_A_ELEM, pick_element());
		rush_items = 1'b0;
		settle_block();
	endtask

	// A rows register above its maximum acts as 1024 rows; run past the end of
	// the matrix to see the last-row flag and the wrap of the row index.
	task automatic test_full_height();
		write_reg(REG_ROWS_M, 32'd2047);
		write_reg(REG_INNER_N, 32'd1);
		write_reg(REG_COLS_P, 32'd1);
		write_reg(REG_A_OFFSET, 32'(pick_offset()));
		write_reg(REG_B_OFFSET, 32'(pick_offset()));
		write_reg(REG_C_OFFSET, pick_c_offset());
		offer_word(CMD_LOAD_B, pick_element());
		repeat (MAX_ROWS + 3) offer_word(CMD_A_ELEM, pick_element());
		settle_block();
	endtask

	// Random matrices: random shape and offsets, a full B load, then whole rows
	// of A. Now and then a stray B element breaks a row, and between rows an
	// offset may change while the matrix is under way.
	task automatic test_random_matrices();
		int unsigned sent, m_raw, n_raw, p_raw, n, p, rows;
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			m_raw = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2047) : $urandom_range(0, 6);
			if ($urandom_range(0, 7) == 0) begin
				n_raw = $urandom_range(10, 127);
				p_raw = $urandom_range(0, 2);
			end else begin
				n_raw = $urandom_range(0, 9);
				p_raw = $urandom_range(0, 31);
			end
			write_reg(REG_ROWS_M, m_raw);
			write_reg(REG_INNER_N, n_raw);
			write_reg(REG_COLS_P, p_raw);
			write_reg(REG_A_OFFSET, 32'(pick_offset()));
			write_reg(REG_B_OFFSET, 32'(pick_offset()));
			write_reg(REG_C_OFFSET, pick_c_offset());
			n = eff_dim(n_raw, MAX_INNER);
			p = eff_dim(p_raw, MAX_COLS);
			load_b_random(n * p);
			sent += n * p;
			rows = $urandom_range(1, 6);
			repeat (rows) begin
				repeat (n) begin
					if ($urandom_range(0, 39) == 0) begin
						offer_word(CMD_LOAD_B, pick_element());
						sent++;
					end
					offer_word(CMD_A_ELEM, pick_element());
					sent++;
				end
				if ($urandom_range(0, 5) == 0) begin
					settle_block();
					case ($urandom_range(0, 2))
						0: write_reg(REG_A_OFFSET, 32'(pick_offset()));
						1: write_reg(REG_B_OFFSET, 32'(pick_offset()));
						default: write_reg(REG_C_OFFSET, pick_c_offset());
					endcase
				end
			end
			settle_block();
		end
	endtask

	// Receiver: waits a drawn number of cycles before each word, or once the
	// long hold-off that the back-pressure test asks for.
	initial begin : result_sink
		int stall;
		forever begin
			if (hold_request) begin
				hold_request = 1'b0;
				stall = LONG_HOLD;
			end else begin
				stall = draw_pause(recv_quiet);
			end
			if (stall > 0) begin
				result_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			result_ready <= 1'b1;
			do @(posedge clk); while (!(result_valid && result_ready));
		end
	end

	// Every delivered word is compared field by field with the oldest
	// prediction. Reports are capped so a broken block cannot flood the log.
	always @(posedge clk) begin
		mm_result_t want;
		if (arst_n && result_valid && result_ready) begin
			if (pending_results.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= MAX_REPORTS)
					$display("%0t: unexpected word: value %0d row %0d column %0d",
						$time, result_value, result_row, result_column);
			end else begin
				want = pending_results.pop_front();
				if (result_value !== want.value || result_row !== want.row ||
					result_column !== want.column || row_last !== want.row_last ||
					matrix_last !== want.matrix_last) begin
					mismatch_count++;
					if (mismatch_count <= MAX_REPORTS)
						$display({"%0t: mismatch: expected value %0d row %0d column %0d ",
							"row_last %0b matrix_last %0b, got value %0d row %0d ",
							"column %0d row_last %0b matrix_last %0b"},
							$time, want.value, want.row, want.column, want.row_last,
							want.matrix_last, result_value, result_row, result_column,
							row_last, matrix_last);
				end
			end
		end
	end

	// Watchdog: a run that stops moving ends as a failure.
	always @(posedge clk) begin
		if (!arst_n || (item_valid && item_ready) || (result_valid && result_ready) || psel) begin
			stalled_cycles <= 0;
		end else begin
			stalled_cycles <= stalled_cycles + 1;
			if (stalled_cycles == STALL_LIMIT) begin
				$display("tb_int8_matmul_offset_accumulate_top: done, errors");
				$finish;
			end
		end
	end

	initial begin : run_tests
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_state();
		test_operand_extremes();
		test_stream_restarts();
		test_wide_dims();
		test_backpressure();
		test_full_height();
		test_random_matrices();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (pending_results.size() != 0) begin
			mismatch_count++;
			$display("%0t: %0d predicted words never arrived", $time, pending_results.size());
		end
		if (mismatch_count == 0) begin
			$display("tb_int8_matmul_offset_accumulate_top: done, clean");
		end else begin
			$display("tb_int8_matmul_offset_accumulate_top: done, errors");
		end
		$finish;
	end

endmodule
